// File: sv/lis_length_tracker_assert.svh
// Assertion macros for the LIS length tracker checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef LIS_LENGTH_TRACKER_ASSERT_SVH
`define LIS_LENGTH_TRACKER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LIS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define LIS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/lis_pkg.sv
// Types and fixed constants for the LIS length tracker.
// No dependencies.
package lis_pkg;

	localparam int unsigned VALUE_W   = 31;
	localparam int unsigned LEN_OUT_W = 11;
	localparam logic [LEN_OUT_W-1:0] LEN_FIELD_MAX = 11'd2047;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LAST,
		ST_SEARCH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic idle;
		logic done;
	} ctrl_stat_t;

endpackage

// File: sv/lis_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module lis_ram #(
	parameter int unsigned WIDTH = 31,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/lis_ctrl.sv
// Sequencer for the LIS tracker: last-tail check, binary search, tail update.
// Depends on lis_pkg; drives the tails RAM ports.
module lis_ctrl import lis_pkg::*; #(
	parameter int unsigned MAX_LEN = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_take,
	input  logic [VALUE_W-1:0]             value,
	input  logic                           start_req,
	input  logic                           out_free,
	input  logic [VALUE_W-1:0]             rd_data,
	output logic                           rd_en,
	output logic [$clog2(MAX_LEN)-1:0]     rd_addr,
	output logic                           wr_en,
	output logic [$clog2(MAX_LEN)-1:0]     wr_addr,
	output logic [VALUE_W-1:0]             wr_data,
	output logic [$clog2(MAX_LEN+1)-1:0]   len,
	output logic                           ovf,
	output ctrl_stat_t                     stat
);

	localparam int unsigned AW = $clog2(MAX_LEN);
	localparam int unsigned LW = $clog2(MAX_LEN + 1);

	state_t          state_q, state_d;
	logic [VALUE_W-1:0] v_q;
	logic [LW-1:0]   len_q, len_d, len_eff;
	logic            ovf_q, ovf_d;
	logic [AW-1:0]   lo_q, hi_q, mid_q;
	logic [AW-1:0]   lo_d, hi_d, mid_d;
	logic [AW-1:0]   hi0, lo_c, hi_c, mid_c;
	logic            is_less;

	// tail below value: step right (or append when it is the last tail)
	assign is_less = rd_data < v_q;
	assign len_eff = start_req ? '0 : len_q;
	assign hi0     = AW'(len_q - LW'(1));
	assign lo_c    = is_less ? AW'(mid_q + AW'(1)) : lo_q;
	assign hi_c    = is_less ? hi_q : mid_q;
	assign mid_c   = AW'(lo_c + ((hi_c - lo_c) >> 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					state_d = (len_eff == '0) ? ST_DONE : ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = (is_less || hi0 == '0) ? ST_DONE : ST_SEARCH;
			end
			ST_SEARCH: begin
				if (lo_c == hi_c) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM controls and datapath updates
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = v_q;
		len_d   = len_q;
		ovf_d   = ovf_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		mid_d   = mid_q;
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					ovf_d = start_req ? 1'b0 : ovf_q;
					if (len_eff == '0) begin
						wr_en   = 1'b1;
						wr_data = value;
						len_d   = LW'(1);
					end else begin
						rd_en   = 1'b1;
						rd_addr = AW'(len_eff - LW'(1));
						len_d   = len_eff;
					end
				end
			end
			ST_LAST: begin
				if (is_less) begin
					if (len_q < LW'(MAX_LEN)) begin
						wr_en   = 1'b1;
						wr_addr = len_q[AW-1:0];
						len_d   = LW'(len_q + LW'(1));
					end else begin
						ovf_d = 1'b1;
					end
				end else if (hi0 == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = hi0 >> 1;
					lo_d    = '0;
					hi_d    = hi0;
					mid_d   = hi0 >> 1;
				end
			end
			ST_SEARCH: begin
				lo_d = lo_c;
				hi_d = hi_c;
				if (lo_c == hi_c) begin
					wr_en   = 1'b1;
					wr_addr = lo_c;
				end else begin
					rd_en   = 1'b1;
					rd_addr = mid_c;
					mid_d   = mid_c;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			ovf_q   <= ovf_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			v_q <= value;
		end
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		mid_q <= mid_d;
	end

	assign len       = len_q;
	assign ovf       = ovf_q;
	assign stat.idle = state_q == ST_IDLE;
	assign stat.done = state_q == ST_DONE;

endmodule

// File: sv/lis_length_tracker.sv
// Flow: an input transaction into an empty table writes the first tail and goes straight
// to the result; otherwise the last tail is read and the value appends, overwrites the
// single tail, or a binary search probes the tails RAM (at most clog2(MAX_LEN) probes,
// 10 at 1024) before the tail is written. One item in flight; the next input transaction
// is taken the cycle after the result is loaded, even while it is still stalled.
// Reset clears length, overflow and control; the tails RAM is not cleared.
module lis_length_tracker import lis_pkg::*; #(
	parameter int unsigned MAX_LEN = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [VALUE_W-1:0]   value,
	input  logic                 start_req,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [LEN_OUT_W-1:0] lis_length,
	output logic                 overflow
);

	localparam int unsigned AW = $clog2(MAX_LEN);
	localparam int unsigned LW = $clog2(MAX_LEN + 1);

	ctrl_stat_t         stat;
	logic               in_take, out_free, out_load;
	logic               rd_en, wr_en;
	logic [AW-1:0]      rd_addr, wr_addr;
	logic [VALUE_W-1:0] rd_data, wr_data;
	logic [LW-1:0]      len;
	logic               ovf;
	logic [31:0]        len_wide;

	logic                 out_valid_q;
	logic [LEN_OUT_W-1:0] lis_length_q;
	logic                 overflow_q;

	// input side: one transaction at a time, only while the sequencer is idle
	assign in_stall = !stat.idle;
	assign in_take  = in_valid && stat.idle;

	// result register frees when empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = stat.done && out_free;

	lis_ctrl #(
		.MAX_LEN (MAX_LEN)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_take   (in_take),
		.value     (value),
		.start_req (start_req),
		.out_free  (out_free),
		.rd_data   (rd_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.len       (len),
		.ovf       (ovf),
		.stat      (stat)
	);

	// tails table: tails[k] is the smallest end of an increasing run of length k+1
	lis_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (MAX_LEN)
	) u_tails (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// length field saturates when the table is deeper than the field can show
	assign len_wide = 32'(len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			lis_length_q <= (len_wide > 32'(LEN_FIELD_MAX)) ? LEN_FIELD_MAX
			                                                : len_wide[LEN_OUT_W-1:0];
			overflow_q   <= ovf;
		end
	end

	assign out_valid  = out_valid_q;
	assign lis_length = lis_length_q;
	assign overflow   = overflow_q;

endmodule

// File: sv/lis_checker.sv
// Port-level checks for the LIS length tracker, bound to the top level.
// Depends on lis_pkg and lis_length_tracker_assert.svh.
`include "lis_length_tracker_assert.svh"

module lis_checker import lis_pkg::*; #(
	parameter int unsigned MAX_LEN = 1024
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic [VALUE_W-1:0]   value,
	input logic                 start_req,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [LEN_OUT_W-1:0] lis_length,
	input logic                 overflow
);

	localparam int unsigned SAT_LEN = (MAX_LEN > 2047) ? 2047 : MAX_LEN;

	`LIS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(lis_length) && $stable(overflow), "stalled result changed")
	`LIS_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "second transaction taken while busy")
	`LIS_ASSERT_NOW(a_len_nonzero, out_valid, lis_length != '0, "result with zero length")
	`LIS_ASSERT_NOW(a_ovf_full, out_valid && overflow, lis_length == LEN_OUT_W'(SAT_LEN), "overflow without full table")

endmodule

bind lis_length_tracker lis_checker #(.MAX_LEN(MAX_LEN)) u_lis_checker (.*);

// File: test/tb_lis_length_tracker.sv
// Testbench for lis_length_tracker: random and directed value streams, checked per result
// against a patience-sort predictor held in a small scoreboard class.
// Depends on lis_pkg and the lis_length_tracker RTL only.
`timescale 1ns / 100ps

module tb_lis_length_tracker;
	import lis_pkg::*;

	localparam int unsigned TABLE_DEPTH = 1024;
	localparam int unsigned ITEM_TARGET = 1850;
	localparam int unsigned MAX_REPORTS = 10;
	localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

	// value shapes for the random sequences
	typedef enum int unsigned {
		SHAPE_NARROW,
		SHAPE_FULL,
		SHAPE_RISING,
		SHAPE_CORNER
	} shape_t;

	typedef struct packed {
		logic [LEN_OUT_W-1:0] len;
		logic                 ovf;
	} tally_t;

	// Scoreboard: own copy of the tails table, predicts one tally per input transaction
	// and holds it until the matching output transaction turns up.
	class lis_scoreboard;
		logic [VALUE_W-1:0] tails [TABLE_DEPTH];
		int unsigned        depth;
		logic               ovf_seen;
		tally_t             due [$];
		int unsigned        failures;

		function new();
			depth    = 0;
			ovf_seen = 1'b0;
			failures = 0;
		endfunction

		function void flag(string msg);
			failures++;
			if (failures <= MAX_REPORTS)
				$display("%0t: mismatch: %s", $realtime, msg);
		endfunction

		// patience step: extend, or overwrite the first tail not below v
		function void note_input(logic [VALUE_W-1:0] v, logic restart);
			int unsigned lo, hi, mid;
			tally_t      t;
			if (restart) begin
				depth    = 0;
				ovf_seen = 1'b0;
			end
			if (depth == 0 || tails[depth-1] < v) begin
				if (depth < TABLE_DEPTH) begin
					tails[depth] = v;
					depth++;
				end else begin
					ovf_seen = 1'b1;
				end
			end else begin
				lo = 0;
				hi = depth;
				while (lo < hi) begin
					mid = lo + ((hi - lo) >> 1);
					if (tails[mid] < v)
						lo = mid + 1;
					else
						hi = mid;
				end
				tails[lo] = v;
			end
			t.len = (depth > LEN_FIELD_MAX) ? LEN_FIELD_MAX : LEN_OUT_W'(depth);
			t.ovf = ovf_seen;
			due.insert(due.size(), t);
		endfunction

		function void check_result(logic [LEN_OUT_W-1:0] got_len, logic got_ovf);
			tally_t t;
			if (due.size() == 0) begin
				flag($sformatf("result len=%0d ovf=%0b with nothing expected", got_len, got_ovf));
				return;
			end
			t = due.pop_front();
			if (got_len !== t.len)
				flag($sformatf("lis_length expected %0d got %0d", t.len, got_len));
			if (got_ovf !== t.ovf)
				flag($sformatf("overflow expected %0b got %0b", t.ovf, got_ovf));
		endfunction

		function int unsigned pending();
			return due.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [VALUE_W-1:0]   value;
	logic                 start_req;
	logic                 out_valid;
	logic                 out_stall;
	logic [LEN_OUT_W-1:0] lis_length;
	logic                 overflow;

	lis_scoreboard sb = new();
	int unsigned   items_sent   = 0;
	int unsigned   results_seen = 0;

	lis_length_tracker #(
		.MAX_LEN(TABLE_DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.start_req (start_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.lis_length(lis_length),
		.overflow  (overflow)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// One input transaction. Inputs move on the falling edge, the handshake is
	// sampled on the rising edge. Random idle cycles go in front, except in a
	// window of the run where the sender never idles.
	task automatic send_item(input logic [VALUE_W-1:0] v, input logic restart);
		bit quiet;
		quiet = (items_sent >= 300 && items_sent < 700);
		@(negedge clk);
		if (!quiet) begin
			while ($urandom_range(99) < 24) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid  <= 1'b1;
		value     <= v;
		start_req <= restart;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_input(v, restart);
		items_sent++;
	endtask

	// Receiver: random stall, a quiet window, and one long hold-off early in the
	// table-filling run so that the block backs up and stalls its input.
	initial begin : receiver
		int unsigned hold_left;
		bit          quiet;
		bit          held;
		hold_left = 0;
		held      = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			quiet = (results_seen >= 1000 && results_seen < 1400);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (!quiet && $urandom_range(99) < 24) begin
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				sb.check_result(lis_length, overflow);
				results_seen++;
				if (results_seen == 60 && !held) begin
					held      = 1'b1;
					hold_left = 400;
				end
			end
		end
	end

	initial begin : stimulus
		int unsigned      top, ext, run_len, k;
		logic [VALUE_W-1:0] v;
		logic             restart;
		shape_t           shape;

		in_valid  = 1'b0;
		value     = '0;
		start_req = 1'b0;
		arst_n    = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: no start after reset, so the first value simply appends
		send_item(31'd5, 1'b0);
		send_item(31'd5, 1'b0);            // equal value leaves the table alone
		send_item(31'd3, 1'b0);            // smaller value overwrites entry 0
		send_item(VALUE_MAX, 1'b0);
		send_item(31'd0, 1'b0);
		send_item(VALUE_MAX, 1'b0);        // equal to the last tail: no extension
		send_item(31'd100, 1'b0);          // replaces the last tail
		send_item(31'd101, 1'b0);
		send_item(31'd0, 1'b1);            // new sequence starting at zero
		send_item(31'd0, 1'b0);
		send_item(31'd1, 1'b0);
		send_item(VALUE_MAX, 1'b1);        // new sequence starting at the top value
		send_item(VALUE_MAX - 1, 1'b0);
		send_item(VALUE_MAX, 1'b0);
		send_item(31'd10, 1'b1);
		send_item(31'd20, 1'b0);
		send_item(31'd30, 1'b0);
		send_item(31'd15, 1'b0);
		send_item(31'd25, 1'b0);
		send_item(31'd35, 1'b0);
		send_item(31'd20, 1'b0);           // between two middle tails: replaces 25
		send_item(31'h5555_5555, 1'b0);
		send_item(31'h2AAA_AAAA, 1'b1);

		// sender holds back until the block has drained completely
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);

		// fill the table past its depth: mostly extensions, some overwrites,
		// last extension attempt at the top value, after the saturated state is hit
		top = $urandom_range(1000);
		send_item(VALUE_W'(top), 1'b1);
		ext = 1;
		while (ext < TABLE_DEPTH + 12) begin
			if ($urandom_range(9) == 0) begin
				send_item(VALUE_W'($urandom_range(top)), 1'b0);
			end else begin
				top += $urandom_range(1 << 20, 1);
				ext++;
				send_item((ext == TABLE_DEPTH + 12) ? VALUE_MAX : VALUE_W'(top), 1'b0);
			end
		end
		// overwrites and a repeat of the top value while overflowed
		send_item(VALUE_W'($urandom_range(top)), 1'b0);
		send_item(VALUE_MAX, 1'b0);

		// random short sequences of various shapes, with a few stray starts
		while (items_sent < ITEM_TARGET) begin
			run_len = $urandom_range(40, 1);
			shape   = shape_t'($urandom_range(3));
			top     = $urandom_range(1000);
			for (k = 0; k < run_len; k++) begin
				restart = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
				case (shape)
					SHAPE_NARROW: begin
						v = VALUE_W'($urandom_range(15));
					end
					SHAPE_FULL: begin
						v = VALUE_W'($urandom());
					end
					SHAPE_RISING: begin
						if ($urandom_range(3) == 0) begin
							v = VALUE_W'($urandom_range(top));
						end else begin
							top += $urandom_range(5000, 1);
							v = VALUE_W'(top);
						end
					end
					default: begin
						case ($urandom_range(3))
							0: v = '0;
							1: v = VALUE_MAX;
							2: v = VALUE_W'(1) << $urandom_range(VALUE_W - 1);
							default: v = ~(VALUE_W'(1) << $urandom_range(VALUE_W - 1));
						endcase
					end
				endcase
				send_item(v, restart);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;

		// drain, then wait on to catch any stray result
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (sb.pending() != 0)
			sb.flag($sformatf("%0d results never arrived", sb.pending()));

		if (sb.failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// hard stop, several times the slowest expected run
	initial begin : watchdog
		#4_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/lis_pkg.sv
sv/lis_ram.sv
sv/lis_ctrl.sv
sv/lis_length_tracker.sv
sv/lis_checker.sv
test/tb_lis_length_tracker.sv
